@@ hdl/lpfs_pkg.sv @@
// Shared types and constants for the LED panel frame store and scan core.
// No dependencies; used by lpfs_store, lpfs_outbuf and the top level.
`timescale 1ns / 1ps
`default_nettype none

package lpfs_pkg;

	localparam int FRAME_BYTES = 64;
	localparam int ADDR_W      = 6;

	localparam logic [2:0] OP_PIXEL  = 3'd0;
	localparam logic [2:0] OP_FILL   = 3'd1;
	localparam logic [2:0] OP_BYTE   = 3'd2;
	localparam logic [2:0] OP_SCROLL = 3'd3;
	localparam logic [2:0] OP_SCAN   = 3'd4;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} rd_req_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} wr_req_t;

	typedef struct packed {
		logic       last;
		logic       latch_strobe;
		logic [1:0] row_select;
		logic [7:0] shift_byte;
	} out_word_t;

endpackage

`default_nettype wire

@@ hdl/lpfs_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lpfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ hdl/lpfs_store.sv @@
// Frame store: RAM plus per-entry valid bits and a fill value for unwritten entries.
// Depends on lpfs_pkg and lpfs_ram.
`timescale 1ns / 1ps
`default_nettype none

module lpfs_store #(
	parameter int FRAME_BYTES = lpfs_pkg::FRAME_BYTES
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lpfs_pkg::rd_req_t rd,
	input  wire lpfs_pkg::wr_req_t wr,
	input  wire logic              fill_en,
	input  wire logic [7:0]        fill_value,
	output      logic [7:0]        rdata
);

	logic [FRAME_BYTES-1:0] valid_q;
	logic [7:0]             fill_q;
	logic                   hit_s1;
	logic [7:0]             ram_rdata;

	lpfs_ram #(
		.WIDTH(8),
		.DEPTH(FRAME_BYTES)
	) u_ram (
		.clk  (clk),
		.we   (wr.en),
		.waddr(wr.addr),
		.wdata(wr.data),
		.re   (rd.en),
		.raddr(rd.addr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			fill_q  <= '0;
		end else if (fill_en) begin
			valid_q <= '0;
			fill_q  <= fill_value;
		end else if (wr.en) begin
			valid_q[wr.addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			hit_s1 <= valid_q[rd.addr];
		end
	end

	assign rdata = hit_s1 ? ram_rdata : fill_q;

`ifndef SYNTHESIS
	a_no_same_entry_rw: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd.en && wr.en && rd.addr == wr.addr))
		else $error("read and write of the same store entry in one cycle");

	a_no_fill_with_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(fill_en && (wr.en || rd.en)))
		else $error("fill overlaps a store access");
`endif

endmodule

`default_nettype wire

@@ hdl/lpfs_outbuf.sv @@
// Two-word output buffer (output register plus skid) for scan words.
// Depends on lpfs_pkg; reports whether one more read may be issued.
`timescale 1ns / 1ps
`default_nettype none

module lpfs_outbuf (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire lpfs_pkg::out_word_t push_word,
	output      logic                can_issue,
	output      logic                m_tvalid,
	input  wire logic                m_tready,
	output      logic [7:0]          m_tdata,  // shift_byte[7:0]
	output      logic [2:0]          m_tuser,  // row_select[1:0], latch_strobe[2]
	output      logic                m_tlast
);

	lpfs_pkg::out_word_t out_q;
	lpfs_pkg::out_word_t skid_q;
	logic                out_valid_q;
	logic                skid_valid_q;
	logic                pop;
	logic [1:0]          occ_next;

	assign pop      = out_valid_q && m_tready;
	assign occ_next = {1'b0, out_valid_q} + {1'b0, skid_valid_q} + {1'b0, push}
		- {1'b0, pop};
	assign can_issue = (occ_next <= 2'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= push;
			end else begin
				out_valid_q <= push;
			end
		end else if (!out_valid_q) begin
			out_valid_q <= push;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
				if (push) begin
					skid_q <= push_word;
				end
			end else if (push) begin
				out_q <= push_word;
			end
		end else if (!out_valid_q) begin
			if (push) begin
				out_q <= push_word;
			end
		end else if (push) begin
			skid_q <= push_word;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q.shift_byte;
	assign m_tuser  = {out_q.latch_strobe, out_q.row_select};
	assign m_tlast  = out_q.last;

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !(out_valid_q && skid_valid_q && !pop))
		else $error("scan word pushed into a full output buffer");

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid word held with an empty output register");
`endif

endmodule

`default_nettype wire

@@ hdl/led_panel_framebuffer_scan_core.sv @@
// Top level of the LED panel frame store and scan core.
// Depends on lpfs_pkg, lpfs_store (with lpfs_ram) and lpfs_outbuf.
//
// Input words (s_*) carry one operation each: pixel write, fill, byte write,
// scroll left or frame scan. Output words (m_*) are the 64 bytes of a frame
// scan, inverted, in panel shift order, four row groups of 16 bytes.
// Store work per input word: fill and byte write, done on acceptance; pixel write,
// a read, then a write back through the store's single read and write ports (none
// when the pixel is off the panel); scroll, one store read per byte, 64 bytes,
// write back one byte behind the reads; frame scan, a store read walk gated by
// room in the two-word output buffer.
// m_tvalid for the first scan byte rises after the scan state register, the
// store's registered read and the output register; bytes then follow one per
// cycle while the receiver takes every byte. The last byte carries m_tlast; the
// 16th of each group carries the latch flag.
// When the receiver stalls, the scan walk pauses with the buffer full and
// resumes without loss. A new input word may be accepted while the last scan
// bytes are still waiting in the buffer.
// Reset: the store reads as all zeros at once (per-entry valid bits), with no
// clearing pass; the output buffer empties.
`timescale 1ns / 1ps
`default_nettype none

module led_panel_framebuffer_scan_core #(
	parameter int FRAME_BYTES = lpfs_pkg::FRAME_BYTES
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	// pixel_x[7:0], pixel_y[15:8], pixel_bits[31:16], byte_index[37:32],
	// byte_value[45:38], zeros[47:46]
	input  wire logic [47:0] s_tdata,
	input  wire logic [2:0]  s_tuser,  // op[2:0]
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [7:0]  m_tdata,  // shift_byte[7:0]
	output      logic [2:0]  m_tuser,  // row_select[1:0], latch_strobe[2]
	output      logic        m_tlast
);

	typedef enum logic [1:0] {ST_IDLE, ST_SCROLL, ST_SCAN} state_t;
	typedef enum logic [1:0] {K_PIX, K_SCRL, K_SCAN} kind_t;

	state_t                        state_q;
	logic [lpfs_pkg::ADDR_W-1:0]   cnt_q;
	logic                          vld_s1;
	kind_t                         kind_s1;
	kind_t                         kind_next;
	logic [lpfs_pkg::ADDR_W-1:0]   addr_s1;
	logic [7:0]                    mask_s1;
	logic                          set_s1;
	logic                          first_s1;
	logic [3:0]                    row_s1;
	logic [1:0]                    rsel_s1;
	logic                          latch_s1;
	logic                          last_s1;
	logic                          carry_q;
	logic [15:0]                   bits_q;

	logic                          accept;
	logic [2:0]                    op;
	logic [7:0]                    pixel_x;
	logic [7:0]                    pixel_y;
	logic [15:0]                   pixel_bits;
	logic [5:0]                    byte_index;
	logic [7:0]                    byte_value;
	logic                          in_range;
	logic [7:0]                    pix_mask;

	lpfs_pkg::rd_req_t             rd;
	lpfs_pkg::wr_req_t             wr;
	logic                          fill_en;
	logic [7:0]                    rdata;
	logic                          push;
	lpfs_pkg::out_word_t           push_word;
	logic                          can_issue;

	assign op         = s_tuser;
	assign pixel_x    = s_tdata[7:0];
	assign pixel_y    = s_tdata[15:8];
	assign pixel_bits = s_tdata[31:16];
	assign byte_index = s_tdata[37:32];
	assign byte_value = s_tdata[45:38];

	assign s_tready = (state_q == ST_IDLE) && !vld_s1;
	assign accept   = s_tvalid && s_tready;
	assign in_range = (pixel_x[7:5] == 3'd0) && (pixel_y[7:4] == 4'd0);
	assign pix_mask = 8'h80 >> pixel_x[2:0];

	always_comb begin
		rd        = '0;
		wr        = '0;
		fill_en   = 1'b0;
		kind_next = K_PIX;
		case (state_q)
			ST_IDLE: begin
				if (accept && op == lpfs_pkg::OP_PIXEL && in_range) begin
					rd.en   = 1'b1;
					rd.addr = {pixel_x[4], pixel_y[3:0], pixel_x[3]};
				end
			end
			ST_SCROLL: begin
				rd.en     = 1'b1;
				rd.addr   = {~cnt_q[1], cnt_q[5:2], ~cnt_q[0]};
				kind_next = K_SCRL;
			end
			ST_SCAN: begin
				rd.en     = can_issue;
				rd.addr   = {cnt_q[3], ~cnt_q[1:0], cnt_q[5:4], cnt_q[2]};
				kind_next = K_SCAN;
			end
			default: begin
				rd.en = 1'b0;
			end
		endcase

		if (accept && op == lpfs_pkg::OP_BYTE) begin
			wr.en   = 1'b1;
			wr.addr = byte_index;
			wr.data = byte_value;
		end
		fill_en = accept && op == lpfs_pkg::OP_FILL;

		if (vld_s1) begin
			case (kind_s1)
				K_PIX: begin
					wr.en   = 1'b1;
					wr.addr = addr_s1;
					wr.data = set_s1 ? (rdata | mask_s1) : (rdata & ~mask_s1);
				end
				K_SCRL: begin
					wr.en   = 1'b1;
					wr.addr = addr_s1;
					wr.data = {rdata[6:0], first_s1 ? bits_q[row_s1] : carry_q};
				end
				default: begin
					wr.en = wr.en;
				end
			endcase
		end
	end

	assign push      = vld_s1 && kind_s1 == K_SCAN;
	assign push_word = '{last: last_s1, latch_strobe: latch_s1, row_select: rsel_s1,
		shift_byte: ~rdata};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			vld_s1  <= 1'b0;
			kind_s1 <= K_PIX;
		end else begin
			vld_s1 <= rd.en;
			if (rd.en) begin
				kind_s1 <= kind_next;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						if (op == lpfs_pkg::OP_SCROLL) begin
							state_q <= ST_SCROLL;
						end else if (op == lpfs_pkg::OP_SCAN) begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCROLL: begin
					cnt_q <= cnt_q + 1'b1;
					if (&cnt_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					if (rd.en) begin
						cnt_q <= cnt_q + 1'b1;
						if (&cnt_q) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			addr_s1  <= rd.addr;
			mask_s1  <= pix_mask;
			set_s1   <= |pixel_bits[7:0];
			first_s1 <= (cnt_q[1:0] == 2'd0);
			row_s1   <= cnt_q[5:2];
			rsel_s1  <= cnt_q[5:4];
			latch_s1 <= &cnt_q[3:0];
			last_s1  <= &cnt_q;
		end
		if (vld_s1 && kind_s1 == K_SCRL) begin
			carry_q <= rdata[7];
		end
		if (accept && op == lpfs_pkg::OP_SCROLL) begin
			bits_q <= pixel_bits;
		end
	end

	lpfs_store #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd        (rd),
		.wr        (wr),
		.fill_en   (fill_en),
		.fill_value(byte_value),
		.rdata     (rdata)
	);

	lpfs_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_word(push_word),
		.can_issue(can_issue),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

`ifndef SYNTHESIS
	a_scroll_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCROLL && (&cnt_q)) |=>
		(state_q == ST_IDLE && vld_s1 && kind_s1 == K_SCRL))
		else $error("scroll walk did not end with its last write back");

	a_pixel_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && kind_s1 == K_PIX) |-> $past(accept))
		else $error("pixel write back without an accepted word");
`endif

endmodule

`default_nettype wire
